// File: src/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SLFE_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Same-cycle implication.
`define SLFE_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/slfe_pkg.sv
// Package for the sync/length frame extractor: constants, register indexes and shared types.
package slfe_pkg;

    localparam int HDR_HELD        = 10;
    localparam int LEN_OFFSET      = 8;
    localparam int CRC_BYTES       = 4;
    localparam int SYNC_BYTES      = 3;
    localparam int MAX_RAW_LEN_DEF = 16384;

    localparam int CNT_W      = 4;
    localparam int SUM_W      = 17;
    localparam int IDX_W      = 14;
    localparam int CFG_ADDR_W = 2;
    localparam int TDATA_W    = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_FIRST    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_SECOND   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_THIRD    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_LENGTH = 2'd3;

    localparam logic [7:0] SYNC_FIRST_RST    = 8'd170;
    localparam logic [7:0] SYNC_SECOND_RST   = 8'd68;
    localparam logic [7:0] SYNC_THIRD_RST    = 8'd18;
    localparam logic [7:0] HEADER_LENGTH_RST = 8'd28;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] din;
    } hold_ctl_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [7:0]       b2;
        logic [7:0]       len_lo;
        logic [7:0]       len_hi;
    } hold_stat_t;

endpackage

// File: src/sync_length_frame_extractor_core.sv
// Three-byte sync, length-field deframer: top level with sequencer and output register.
// Usage:
//   s_tdata[7:0] carries one received byte per transaction on the slave channel.
//   Results leave on the master channel: m_tdata holds the byte and its frame
//   position, m_tlast marks the final frame byte (CRC included), m_tuser flags
//   a dropped frame whose length field plus header length exceeded the limit.
//   cfg_valid/cfg_addr/cfg_data write the sync bytes and header length;
//   cfg_ready is always high. Write them only while the block is idle.
// Sequence:
//   While hunting, a byte is accepted and the window is then scanned, dropping
//   front bytes until it matches the sync bytes or fewer than three bytes are
//   held; no new byte is accepted until the scan ends. A found header goes to
//   the length check, then the header bytes are sent one by one, each waiting
//   on a free master channel; an over-limit length sends one result and
//   scans the nine remaining bytes again.
//   While passing frame bytes, one byte per cycle while the receiver takes each
//   result: each is registered at accept and shows on the master channel in the next cycle.
//   The front-drop shift line and the single window compare set the hunting pace.
// Reset: aresetn (synchronous, active low) empties the hold line, returns to
//   hunting and restores the register defaults.
// Stall: a held result stays on the master channel until taken; the sequencer
//   waits on it to give a result, and the slave channel waits on it in pass only.
`include "assert_macros.svh"

module sync_length_frame_extractor_core #(
    parameter int MAX_RAW_LEN = slfe_pkg::MAX_RAW_LEN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: in_byte[7:0]
    input  logic [7:0]                        s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: data_byte[7:0], byte_index[21:8], zero [23:22]
    output logic [slfe_pkg::TDATA_W-1:0]      m_tdata,
    output logic                              m_tlast,
    // m_tuser: length_error[0]
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [slfe_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [7:0]                        cfg_data
);
    import slfe_pkg::*;

    localparam int FLW = $clog2(MAX_RAW_LEN + 1);
    localparam logic [SUM_W-1:0] LIMIT = SUM_W'(MAX_RAW_LEN - CRC_BYTES);

    typedef enum logic [4:0] {
        ST_HUNT  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_PASS  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [FLW-1:0]   cnt_reg, cnt_next;
    logic [FLW-1:0]   flen_reg, flen_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    logic [7:0] sync_first_reg, sync_second_reg, sync_third_reg, hdr_len_reg;

    logic               m_tvalid_reg;
    logic [TDATA_W-1:0] m_tdata_reg;
    logic               m_tlast_reg;
    logic               m_tuser_reg;

    logic             out_free;
    logic             out_load;
    logic [7:0]       out_byte;
    logic [IDX_W-1:0] out_index;
    logic             out_last;
    logic             out_err;
    logic             s_accept;
    logic             match;
    logic             at_last;

    hold_ctl_t  ctl;
    hold_stat_t stat;

    slfe_hold u_hold (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .stat    (stat)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_HUNT) || ((state_reg == ST_PASS) && out_free);
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign match = (stat.b0 == sync_first_reg) && (stat.b1 == sync_second_reg) &&
                   (stat.b2 == sync_third_reg);
    // Shared end-of-frame compare for header emission and pass-through.
    assign at_last = ({1'b0, cnt_reg} + (FLW + 1)'(1)) >= {1'b0, flen_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        flen_next  = flen_reg;
        sum_next   = sum_reg;
        ctl        = '0;
        out_load   = 1'b0;
        out_byte   = '0;
        out_index  = '0;
        out_last   = 1'b0;
        out_err    = 1'b0;
        case (state_reg)
            ST_HUNT: begin
                if (s_accept) begin
                    ctl.push   = 1'b1;
                    ctl.pop    = (stat.count == CNT_W'(HDR_HELD));
                    ctl.din    = s_tdata;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.count < CNT_W'(SYNC_BYTES)) begin
                    state_next = ST_HUNT;
                end else if (match) begin
                    if (stat.count < CNT_W'(HDR_HELD)) begin
                        state_next = ST_HUNT;
                    end else begin
                        sum_next   = SUM_W'({stat.len_hi, stat.len_lo}) + SUM_W'(hdr_len_reg);
                        state_next = ST_CHECK;
                    end
                end else begin
                    // advance the window past a byte that cannot start a sync
                    ctl.pop = 1'b1;
                end
            end
            ST_CHECK: begin
                if (sum_reg > LIMIT) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_err    = 1'b1;
                        ctl.pop    = 1'b1;
                        state_next = ST_SCAN;
                    end
                end else begin
                    flen_next  = FLW'(sum_reg + SUM_W'(CRC_BYTES));
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_byte  = stat.b0;
                    out_index = IDX_W'(cnt_reg);
                    out_last  = at_last;
                    ctl.pop   = 1'b1;
                    if (at_last) begin
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end else if (cnt_reg == FLW'(HDR_HELD - 1)) begin
                        cnt_next   = FLW'(HDR_HELD);
                        state_next = ST_PASS;
                    end else begin
                        cnt_next = cnt_reg + FLW'(1);
                    end
                end
            end
            ST_PASS: begin
                if (s_accept) begin
                    out_load  = 1'b1;
                    out_byte  = s_tdata;
                    out_index = IDX_W'(cnt_reg);
                    out_last  = at_last;
                    if (at_last) begin
                        cnt_next   = '0;
                        state_next = ST_HUNT;
                    end else begin
                        cnt_next = cnt_reg + FLW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
            cnt_reg   <= '0;
            flen_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            flen_reg  <= flen_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            sync_third_reg  <= SYNC_THIRD_RST;
            hdr_len_reg     <= HEADER_LENGTH_RST;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_SYNC_FIRST:    sync_first_reg  <= cfg_data;
                REG_SYNC_SECOND:   sync_second_reg <= cfg_data;
                REG_SYNC_THIRD:    sync_third_reg  <= cfg_data;
                REG_HEADER_LENGTH: hdr_len_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Hold a result until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= TDATA_W'({out_index, out_byte});
            m_tlast_reg <= out_last;
            m_tuser_reg <= out_err;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `SLFE_IMPLY(a_pass_empty, state_reg == ST_PASS, stat.count == '0, "hold line not empty in pass")
    `SLFE_IMPLY(a_err_no_last, m_tvalid_reg && m_tuser_reg, !m_tlast_reg, "error result marked last")
    `SLFE_IMPLY(a_emit_in_frame, state_reg == ST_EMIT, cnt_reg < flen_reg, "header index past frame")

endmodule

// File: src/slfe_hold.sv
// Header hold line: ten byte shift line with append at the fill level and drop at the front.
`include "assert_macros.svh"

module slfe_hold (
    input  logic                aclk,
    input  logic                aresetn,
    input  slfe_pkg::hold_ctl_t  ctl,
    output slfe_pkg::hold_stat_t stat
);
    import slfe_pkg::*;

    logic [7:0]       store_reg [HDR_HELD];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] wr_addr;

    assign wr_addr    = count_reg - CNT_W'(ctl.pop);
    assign count_next = count_reg + CNT_W'(ctl.push) - CNT_W'(ctl.pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Drop the front byte by shifting down; the appended byte lands after the shift.
    always_ff @(posedge aclk) begin
        if (ctl.pop) begin
            for (int k = 0; k < HDR_HELD - 1; k++) begin
                store_reg[k] <= store_reg[k + 1];
            end
        end
        if (ctl.push) begin
            store_reg[wr_addr] <= ctl.din;
        end
    end

    assign stat.count  = count_reg;
    assign stat.b0     = store_reg[0];
    assign stat.b1     = store_reg[1];
    assign stat.b2     = store_reg[2];
    assign stat.len_lo = store_reg[LEN_OFFSET];
    assign stat.len_hi = store_reg[LEN_OFFSET + 1];

    `SLFE_ASSERT(a_count_range, count_reg <= CNT_W'(HDR_HELD), "hold count above header size")
    `SLFE_IMPLY(a_push_full, ctl.push && (count_reg == CNT_W'(HDR_HELD)), ctl.pop, "push when full")
    `SLFE_IMPLY(a_pop_nonempty, ctl.pop, count_reg != '0, "drop from empty hold line")

endmodule
